// File: rtl/core/fvn_pkg.sv
package fvn_pkg;

  // Fixed geometry of the lattice and the datapath
  localparam int unsigned MAX_OCTAVES  = 8;
  localparam int unsigned CELL_DIVISOR = 48;
  localparam int unsigned NUM_STAGES   = 13;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CELL_W  = 32;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned TERM_W  = 17;
  localparam int unsigned OCT_W   = 4;

  // The divisor is split into a power of two and a small odd factor
  localparam int unsigned DIV_SH    = 4;
  localparam int unsigned DIV_ODD   = CELL_DIVISOR / (2 ** DIV_SH);
  localparam int unsigned SHIFT_W   = COORD_W + MAX_OCTAVES - 1;
  localparam int unsigned V_W       = SHIFT_W - DIV_SH;
  localparam int unsigned W_W       = V_W + 2;
  localparam int unsigned Q_W       = V_W + 1;
  localparam int unsigned REM_W     = DIV_SH + 2;
  localparam int unsigned RECIP_SH  = W_W + 2;
  localparam int unsigned RECIP_W   = RECIP_SH - 1;
  localparam int unsigned PROD_W    = W_W + RECIP_W;
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + DIV_ODD - 1) / DIV_ODD;
  localparam longint unsigned BIAS  = DIV_ODD * (64'd1 << (V_W - 1));
  localparam longint unsigned QOFS  = 64'd1 << (V_W - 1);

  localparam logic [HASH_W-1:0] HASH_A        = 32'd2654435761;
  localparam logic [HASH_W-1:0] HASH_B        = 32'd3674653429;
  localparam logic [HASH_W-1:0] HASH_C        = 32'd805459861;
  localparam logic [HASH_W-1:0] HASH_MIX      = 32'h045d9f3b;
  localparam logic [HASH_W-1:0] OCT_SEED_STEP = 32'd7919;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVES = 2'd1;

  // Q0.16 fraction of a remainder in [0, CELL_DIVISOR)
  function automatic logic [FRAC_W-1:0] frac_lut(input logic [REM_W-1:0] r);
    logic [FRAC_W-1:0] res;
    res = '0;
    for (int i = 0; i < CELL_DIVISOR; i++) begin
      if (r == REM_W'(i)) begin
        res = FRAC_W'((i * 65536) / CELL_DIVISOR);
      end
    end
    return res;
  endfunction

  // Linear hash offset of corner c (bit 0 x, bit 1 y, bit 2 z)
  function automatic logic [HASH_W-1:0] corner_offset(input int c);
    logic [HASH_W-1:0] res;
    res = '0;
    if (c % 2 == 1)       res = res + HASH_A;
    if ((c / 2) % 2 == 1) res = res + HASH_B;
    if (c / 4 == 1)       res = res + HASH_C;
    return res;
  endfunction

  // floor((a*(65536-u) + b*u) / 65536) as a + floor((b-a)*u / 65536)
  function automatic logic [FRAC_W-1:0] lerp16(input logic [FRAC_W-1:0] a,
                                               input logic [FRAC_W-1:0] b,
                                               input logic [FRAC_W-1:0] u);
    logic signed [FRAC_W:0]     d;
    logic signed [2*FRAC_W+1:0] pr;
    d  = $signed({1'b0, b}) - $signed({1'b0, a});
    pr = d * $signed({1'b0, u});
    return FRAC_W'(a + pr[2*FRAC_W-1:FRAC_W]);
  endfunction

endpackage

// File: rtl/core/fractal_value_noise_3d.sv
// Fractal 3D value noise, one sample per transfer.
// An input transfer reaches the output port through the input register, the lane stages and the sum register.
// Throughput: one sample per cycle; every octave has its own lane, so the
// rate does not depend on octave_count. Each stage holds only under stall.
// Reset (asynchronous, active low) empties the pipeline and sets seed 0, 4 octaves.
module fractal_value_noise_3d import fvn_pkg::*; #(
  parameter int unsigned OCTAVES = MAX_OCTAVES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [HASH_W-1:0]         cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] noise_value_o
);

  // Configuration registers. The user must write them only with the pipeline empty; the block does not
  // enforce it. So the lanes read them live at the stage that needs them.
  logic [HASH_W-1:0] seed_q;
  logic [OCT_W-1:0]  octaves_q;
  logic [OCT_W-1:0]  oct_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= '0;
      octaves_q <= OCT_W'(4);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SEED:    seed_q    <= cfg_data_i;
        REG_OCTAVES: octaves_q <= cfg_data_i[OCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the octave count to the number of lanes built
  assign oct_eff = (octaves_q > OCT_W'(OCTAVES)) ? OCT_W'(OCTAVES) : octaves_q;

  // Stage valid bits and per-stage advance. A stage advances when it is
  // empty or the stage after it advances, so bubbles collapse under stall.
  logic [NUM_STAGES:1] vld_q;
  logic [NUM_STAGES:1] en;

  always_comb begin
    en[NUM_STAGES] = !vld_q[NUM_STAGES] || out_ready_i;
    for (int s = NUM_STAGES - 1; s >= 1; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
  end

  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= in_valid_i;
      for (int s = 2; s <= NUM_STAGES; s++) begin
        if (en[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Input register
  logic signed [COORD_W-1:0] x1_q, y1_q, z1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x1_q <= coord_x_i;
      y1_q <= coord_y_i;
      z1_q <= coord_z_i;
    end
  end

  // One lane per octave; each returns its scaled, centred term
  logic signed [TERM_W-1:0] term [OCTAVES];

  for (genvar k = 0; k < OCTAVES; k++) begin : g_lane
    logic [HASH_W-1:0] lane_seed;
    logic              lane_on;
    assign lane_seed = seed_q + HASH_W'(OCT_SEED_STEP * k);
    assign lane_on   = OCT_W'(k) < oct_eff;
    fvn_octave #(.OCT(k)) u_oct (
      .clk_i,
      .en_i     (en),
      .x_i      (x1_q),
      .y_i      (y1_q),
      .z_i      (z1_q),
      .seed_i   (lane_seed),
      .active_i (lane_on),
      .term_o   (term[k])
    );
  end

  // Sum the octave terms into the output register
  logic [COORD_W-1:0] sum_d;
  logic [COORD_W-1:0] sum_q;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < OCTAVES; k++) begin
      sum_d = sum_d + COORD_W'(term[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NUM_STAGES]) sum_q <= sum_d;
  end

  assign out_valid_o   = vld_q[NUM_STAGES];
  assign noise_value_o = $signed(sum_q);

  // An empty pipeline must always take a transfer
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q == '0 |-> in_ready_o)
    else $error("pipeline empty but input stalled");

  // An accepted sample must occupy the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[1])
    else $error("accepted sample lost at entry");

  // A result held under stall, with no new input, keeps the number of occupied stages
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !in_valid_i |=> $countones(vld_q) == $past($countones(vld_q)))
    else $error("samples created or lost under stall");

endmodule

// File: rtl/core/fvn_axis.sv
module fvn_axis import fvn_pkg::*; #(
  parameter int unsigned OCT = 0
) (
  input  logic                      clk_i,
  input  logic [NUM_STAGES:1]       en_i,
  input  logic signed [COORD_W-1:0] coord_i,
  output logic [CELL_W-1:0]         cell_o,
  output logic [FRAC_W-1:0]         frac_o
);

  logic signed [SHIFT_W-1:0] p;
  logic [V_W-1:0]            v;
  logic [W_W-1:0]            w_d, w_q;
  logic [PROD_W-1:0]         prod_d, prod_q;
  logic [DIV_SH-1:0]         lo_q;
  logic [Q_W-1:0]            q3, qv;
  logic [W_W-1:0]            rem;
  logic [CELL_W-1:0]         cell_q;
  logic [FRAC_W-1:0]         frac_q;

  // Scale, drop the power-of-two part, bias to non-negative, multiply by reciprocal
  always_comb begin
    p      = SHIFT_W'(coord_i) <<< OCT;
    v      = p[SHIFT_W-1:DIV_SH];
    w_d    = {{2{v[V_W-1]}}, v} + W_W'(BIAS);
    prod_d = PROD_W'(w_d) * PROD_W'(RECIP);
  end

  always_comb begin
    q3  = prod_q[RECIP_SH +: Q_W];
    qv  = q3 - Q_W'(QOFS);
    rem = w_q - W_W'(q3) - (W_W'(q3) << 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      w_q    <= w_d;
      prod_q <= prod_d;
      lo_q   <= p[DIV_SH-1:0];
    end
    if (en_i[3]) begin
      cell_q <= CELL_W'($signed(qv));
      frac_q <= frac_lut({rem[1:0], lo_q});
    end
  end

  assign cell_o = cell_q;
  assign frac_o = frac_q;

endmodule

// File: rtl/core/fvn_hash.sv
module fvn_hash import fvn_pkg::*; #(
  parameter int CORNER = 0
) (
  input  logic                clk_i,
  input  logic [NUM_STAGES:1] en_i,
  input  logic [HASH_W-1:0]   base_i,
  input  logic [HASH_W-1:0]   seed_i,
  output logic [FRAC_W-1:0]   val_o
);

  localparam logic [HASH_W-1:0] OFFSET = corner_offset(CORNER);

  logic [HASH_W-1:0] h0;
  logic [HASH_W-1:0] h1_q, h2_q;
  logic [FRAC_W-1:0] val_q;

  assign h0 = (base_i + OFFSET) ^ seed_i;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) h1_q <= h0 ^ (h0 >> 16);
    if (en_i[7]) h2_q <= HASH_W'(h1_q * HASH_MIX);
    if (en_i[8]) val_q <= h2_q[15:0] ^ h2_q[31:16];
  end

  assign val_o = val_q;

endmodule

// File: rtl/core/fvn_octave.sv
module fvn_octave import fvn_pkg::*; #(
  parameter int unsigned OCT = 0
) (
  input  logic                      clk_i,
  input  logic [NUM_STAGES:1]       en_i,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] y_i,
  input  logic signed [COORD_W-1:0] z_i,
  input  logic [HASH_W-1:0]         seed_i,
  input  logic                      active_i,
  output logic signed [TERM_W-1:0]  term_o
);

  localparam int unsigned SH = OCT + 1;

  logic [CELL_W-1:0] axis_cell [3];
  logic [FRAC_W-1:0] frac [3];
  logic [FRAC_W-1:0] t4_q [3];
  logic [31:0]       tt_q [3];
  logic [HASH_W-1:0] hx_q, hy_q, hz_q, base_q;
  logic [FRAC_W-1:0] u5_q [3];
  logic [FRAC_W-1:0] u6_q [3];
  logic [FRAC_W-1:0] u7_q [3];
  logic [FRAC_W-1:0] u8_q [3];
  logic [FRAC_W-1:0] uy9_q, uz9_q, uz10_q;
  logic [FRAC_W-1:0] cv [8];
  logic [FRAC_W-1:0] a_q [4];
  logic [FRAC_W-1:0] b_q [2];
  logic [FRAC_W-1:0] n_q;
  logic signed [TERM_W-1:0] term_d, term_q;

  fvn_axis #(.OCT(OCT)) u_ax_x (
    .clk_i, .en_i, .coord_i(x_i), .cell_o(axis_cell[0]), .frac_o(frac[0])
  );
  fvn_axis #(.OCT(OCT)) u_ax_y (
    .clk_i, .en_i, .coord_i(y_i), .cell_o(axis_cell[1]), .frac_o(frac[1])
  );
  fvn_axis #(.OCT(OCT)) u_ax_z (
    .clk_i, .en_i, .coord_i(z_i), .cell_o(axis_cell[2]), .frac_o(frac[2])
  );

  for (genvar c = 0; c < 8; c++) begin : g_corner
    fvn_hash #(.CORNER(c)) u_hash (
      .clk_i, .en_i, .base_i(base_q), .seed_i, .val_o(cv[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      hx_q <= HASH_W'(axis_cell[0] * HASH_A);
      hy_q <= HASH_W'(axis_cell[1] * HASH_B);
      hz_q <= HASH_W'(axis_cell[2] * HASH_C);
    end
    if (en_i[5]) base_q <= hx_q + hy_q + hz_q;
  end

  // Smoothstep over two stages, then carry the weights alongside the hashes
  for (genvar a = 0; a < 3; a++) begin : g_weight
    logic [FRAC_W+1:0] f;
    logic [49:0]       sp;
    assign f  = 18'(196608) - {1'b0, t4_q[a], 1'b0};
    assign sp = 50'(tt_q[a]) * 50'(f);
    always_ff @(posedge clk_i) begin
      if (en_i[4]) begin
        t4_q[a] <= frac[a];
        tt_q[a] <= frac[a] * frac[a];
      end
      if (en_i[5]) u5_q[a] <= sp[47:32];
      if (en_i[6]) u6_q[a] <= u5_q[a];
      if (en_i[7]) u7_q[a] <= u6_q[a];
      if (en_i[8]) u8_q[a] <= u7_q[a];
    end
  end

  always_comb begin
    term_d = $signed({1'b0, n_q >> SH}) - $signed(TERM_W'(32768 >> SH));
    if (!active_i) term_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      for (int j = 0; j < 4; j++) a_q[j] <= lerp16(cv[2*j], cv[2*j+1], u8_q[0]);
      uy9_q <= u8_q[1];
      uz9_q <= u8_q[2];
    end
    if (en_i[10]) begin
      b_q[0] <= lerp16(a_q[0], a_q[1], uy9_q);
      b_q[1] <= lerp16(a_q[2], a_q[3], uy9_q);
      uz10_q <= uz9_q;
    end
    if (en_i[11]) n_q <= lerp16(b_q[0], b_q[1], uz10_q);
    if (en_i[12]) term_q <= term_d;
  end

  assign term_o = term_q;

endmodule

// File: tb/tb.sv
module tb;
  import fvn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_RANDOM  = 1630;
  localparam int unsigned PIPE_LAT  = 13;
  localparam int unsigned IDLE_LIM  = 4000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [HASH_W-1:0]         cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] coord_x_i = '0;
  logic signed [COORD_W-1:0] coord_y_i = '0;
  logic signed [COORD_W-1:0] coord_z_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [COORD_W-1:0] noise_value_o;

  fractal_value_noise_3d dut (.*);

  always #6 clk_i = ~clk_i;

  // Shadow copy of the two registers
  logic [31:0] seed_sh = 32'd0;
  logic [3:0]  oct_sh  = 4'd4;

  logic signed [15:0] noise_q[$];
  int unsigned        fails = 0;
  int unsigned        stalled = 0;
  bit                 sink_hold = 1'b0;
  bit                 sink_calm = 1'b0;
  bit                 src_calm  = 1'b0;

  // Directed rows: coordinates, register setting, and a typed-in result where obvious
  typedef struct {
    logic signed [15:0] x, y, z;
    logic [31:0]        seed;
    logic [3:0]         octs;
    bit                 known;
    logic signed [15:0] val;
  } noise_row_t;

  function automatic logic [15:0] corner_hash(logic [31:0] ix, logic [31:0] iy,
                                              logic [31:0] iz, logic [31:0] s);
    logic [31:0] h;
    h = ix * 32'd2654435761 + iy * 32'd3674653429 + iz * 32'd805459861;
    h = h ^ s;
    h = h ^ (h >> 16);
    h = h * 32'h045d9f3b;
    h = h ^ (h >> 16);
    return h[15:0];
  endfunction

  function automatic logic [15:0] ease(logic [15:0] t);
    logic [63:0] tt;
    tt = 64'(t) * 64'(t);
    return 16'((tt * (64'd196608 - 64'd2 * 64'(t))) >> 32);
  endfunction

  function automatic logic [15:0] mix(logic [15:0] a, logic [15:0] b, logic [15:0] u);
    return 16'((64'(a) * (64'd65536 - 64'(u)) + 64'(b) * 64'(u)) >> 16);
  endfunction

  function automatic void cell_of(logic signed [15:0] c, int k,
                                  output logic [31:0] lat, output logic [15:0] fr);
    longint p, q, r;
    p = longint'(c) * (longint'(1) << k);
    q = p / 48;
    r = p % 48;
    if (r < 0) begin
      q = q - 1;
      r = r + 48;
    end
    lat = 32'(q);
    fr  = 16'((r << 16) / 48);
  endfunction

  function automatic logic signed [15:0] fbm_noise(logic signed [15:0] x,
                                                   logic signed [15:0] y,
                                                   logic signed [15:0] z);
    logic [31:0] cx, cy, cz, s;
    logic [15:0] tx, ty, tz, ux, uy, uz, a0, a1, a2, a3, b0, b1, v;
    int n, sum;
    n   = (oct_sh > MAX_OCTAVES) ? MAX_OCTAVES : oct_sh;
    sum = 0;
    for (int k = 0; k < n; k++) begin
      s = seed_sh + 32'd7919 * k;
      cell_of(x, k, cx, tx);
      cell_of(y, k, cy, ty);
      cell_of(z, k, cz, tz);
      ux = ease(tx);
      uy = ease(ty);
      uz = ease(tz);
      a0 = mix(corner_hash(cx, cy, cz, s), corner_hash(cx + 1, cy, cz, s), ux);
      a1 = mix(corner_hash(cx, cy + 1, cz, s), corner_hash(cx + 1, cy + 1, cz, s), ux);
      a2 = mix(corner_hash(cx, cy, cz + 1, s), corner_hash(cx + 1, cy, cz + 1, s), ux);
      a3 = mix(corner_hash(cx, cy + 1, cz + 1, s),
               corner_hash(cx + 1, cy + 1, cz + 1, s), ux);
      b0 = mix(a0, a1, uy);
      b1 = mix(a2, a3, uy);
      v  = mix(b0, b1, uz);
      sum += int'(v >> (k + 1)) - int'(32768 >> (k + 1));
    end
    return 16'(sum);
  endfunction

  // Drop valid only after the last write of a group
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data, bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
    if (idx == REG_SEED) seed_sh = data;
    else                 oct_sh  = data[3:0];
  endtask

  // Hold until the pipeline has drained, then allow for its latency
  task automatic drain();
    in_valid_i <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  // Valid stays high after a transfer; drop it only when idling
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, bit may_idle);
    if (may_idle && !src_calm) begin
      while ($urandom_range(99) < 26) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    coord_x_i  <= x;
    coord_y_i  <= y;
    coord_z_i  <= z;
    noise_q.push_back(fbm_noise(x, y, z));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(200)) - 16'sd100;
      1:       return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(60))
                                        : 16'sh8000 + 16'($urandom_range(60));
      default: return 16'($urandom);
    endcase
  endfunction

  // Result side: check each transfer against the oldest prediction
  always @(posedge clk_i) begin
    logic signed [15:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (noise_q.size() == 0) begin
          $error("noise_value: unexpected result %0d", noise_value_o);
          fails++;
        end else begin
          want = noise_q.pop_front();
          if (noise_value_o !== want) begin
            $error("noise_value: expected %0d, actual %0d", want, noise_value_o);
            fails++;
          end
        end
      end
      out_ready_i <= sink_hold ? 1'b0 : (sink_calm || $urandom_range(99) >= 26);
    end
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || noise_q.size() == 0)
      stalled <= 0;
    else if (stalled >= IDLE_LIM) begin
      $display("fractal_value_noise_3d: mismatch");
      $finish;
    end else
      stalled <= stalled + 1;
  end

  noise_row_t rows[$];
  logic [31:0] seeds[4] = '{32'd0, 32'hffffffff, 32'h1234abcd, 32'h80000001};
  logic [3:0]  octs[6]  = '{4'd1, 4'd8, 4'd4, 4'd0, 4'd15, 4'd9};

  initial begin
    // Octave count zero gives zero whatever the point
    rows.push_back('{16'sh7fff, 16'sh8000, 16'sd0, 32'd0, 4'd0, 1'b1, 16'sd0});
    rows.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff, 32'hffffffff, 4'd0, 1'b1, 16'sd0});
    rows.push_back('{16'sd0, 16'sd0, 16'sd0, 32'd0, 4'd4, 1'b0, 16'sd0});
    rows.push_back('{16'sd47, 16'sd48, 16'sd49, 32'd0, 4'd4, 1'b0, 16'sd0});
    rows.push_back('{-16'sd1, -16'sd48, -16'sd49, 32'd0, 4'd1, 1'b0, 16'sd0});
    rows.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 32'hffffffff, 4'd8, 1'b0, 16'sd0});
    rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 32'hffffffff, 4'd8, 1'b0, 16'sd0});
    // Counts above the maximum saturate to it
    rows.push_back('{16'sh8000, 16'sd5, 16'sh7fff, 32'h5a5a5a5a, 4'd15, 1'b0, 16'sd0});
    rows.push_back('{16'sd1234, -16'sd4321, 16'sd77, 32'h5a5a5a5a, 4'd9, 1'b0, 16'sd0});
    rows.push_back('{-16'sd24, 16'sd24, -16'sd96, 32'h00000001, 4'd2, 1'b0, 16'sd0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].seed != seed_sh || rows[i].octs != oct_sh) begin
        drain();
        write_reg(REG_SEED, rows[i].seed, 1'b0);
        write_reg(REG_OCTAVES, {28'd0, rows[i].octs}, 1'b1);
      end
      send_point(rows[i].x, rows[i].y, rows[i].z, 1'b1);
      if (rows[i].known) noise_q[$] = rows[i].val;
    end

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      if (n % 160 == 0) begin
        drain();
        write_reg(REG_SEED, (n / 160 < 4) ? seeds[n / 160] : $urandom, 1'b0);
        write_reg(REG_OCTAVES,
                  32'((n / 160 < 6) ? octs[n / 160] : 4'($urandom_range(1, 8))), 1'b1);
      end
      // Calm stretch with no idling on either side
      src_calm  = (n >= 400 && n < 560);
      sink_calm = src_calm;
      if (n == 700) begin
        fork
          begin
            sink_hold = 1'b1;
            repeat (80) @(posedge clk_i);
            sink_hold = 1'b0;
          end
        join_none
      end
      // Pause the source until everything has come back
      if (n == 1100) begin
        while (noise_q.size() != 0) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
    end

    drain();
    if (fails == 0)
      $display("fractal_value_noise_3d: match");
    else
      $display("fractal_value_noise_3d: mismatch");
    $finish;
  end

endmodule
